// ===== sv/comb_filter_energy_accumulator_core_assert.svh =====
// Assertion macros shared by the comb filter energy accumulator modules.
// Included by the controller and the datapath; depends on nothing else.
`ifndef COMB_FILTER_ENERGY_ACCUMULATOR_CORE_ASSERT_SVH
`define COMB_FILTER_ENERGY_ACCUMULATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge out of reset.
`define CFEA_ASSERT_PROP(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("%m: check failed");

// A consequence that must hold in the cycle after its antecedent.
`define CFEA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("%m: check failed");

`else

`define CFEA_ASSERT_PROP(lbl, clk, rstn, prop)
`define CFEA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== sv/cfea_pkg.sv =====
// Shared constants and controller/datapath interface types for the comb filter
// energy accumulator. Depends on nothing; used by the controller, datapath and top.
`default_nettype none

package cfea_pkg;

	// Frame and sample geometry.
	localparam int BLOCK_SIZE  = 1024;
	localparam int SAMPLE_BITS = 16;
	localparam int IDX_W       = $clog2(BLOCK_SIZE);
	localparam int CNT_W       = IDX_W + 1;

	// Register and accumulator widths.
	localparam int DELAY_W = 10;
	localparam int GAIN_W  = 16;
	localparam int ACC_W   = 32;
	localparam int PEAK_W  = ACC_W - 1;

	// Width wide enough for index, delay and twice the delay comparisons.
	localparam int CMP_W = ((IDX_W > DELAY_W) ? IDX_W : DELAY_W) + 2;

	// Filter arithmetic widths.
	localparam int PFB_W = SAMPLE_BITS + GAIN_W + 1;
	localparam int PX_W  = SAMPLE_BITS + GAIN_W + 2;
	localparam int SUM_W = SAMPLE_BITS + GAIN_W + 3;
	localparam int Q_W   = SUM_W - GAIN_W;

	// Stream data widths, rounded up to whole bytes.
	localparam int S_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W = ((PEAK_W + 7) / 8) * 8;

	// Configuration port.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_DELAY = 1'b0;
	localparam logic REG_GAIN  = 1'b1;
	localparam logic [DELAY_W-1:0] DELAY_RESET = 10'd512;
	localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd32768;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_start;
		logic clr_step;
		logic peak_clr;
		logic load;
		logic pass_start;
		logic mul_fb;
		logic mul_x;
		logic sum;
		logic acc;
		logic idx_dec;
		logic frame_end;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic idx_zero;
		logic pass_empty;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== sv/cfea_ram.sv =====
// Generic single write port, single read port RAM with a registered read.
// Depends on nothing; holds the frame, filtered and accumulator stores.
`default_nettype none

module cfea_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// ===== sv/cfea_ctrl.sv =====
// Controller of the comb filter energy accumulator: sequences loading, the
// clearing sweep and the backward filter pass. Depends on cfea_pkg.
`default_nettype none
`include "comb_filter_energy_accumulator_core_assert.svh"

module cfea_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	input  wire logic          s_tuser,
	input  wire logic          s_tlast,
	output logic               s_tready,
	input  wire cfea_pkg::sts_t sts,
	output cfea_pkg::cmd_t     cmd
);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_READ   = 3'd2;
	localparam logic [2:0] ST_MUL_FB = 3'd3;
	localparam logic [2:0] ST_MUL_X  = 3'd4;
	localparam logic [2:0] ST_SUM    = 3'd5;
	localparam logic [2:0] ST_ACC    = 3'd6;
	localparam logic [2:0] ST_DONE   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       in_acc;

	// Items are only taken while nothing else is in progress.
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	// Next state and command decode.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_acc) begin
					if (s_tuser) begin
						cmd.peak_clr  = 1'b1;
						cmd.clr_start = 1'b1;
						state_d       = ST_CLEAR;
					end else begin
						cmd.load = 1'b1;
						if (s_tlast) begin
							if (sts.pass_empty) begin
								state_d = ST_DONE;
							end else begin
								cmd.pass_start = 1'b1;
								state_d        = ST_READ;
							end
						end
					end
				end
			end
			ST_READ: begin
				state_d = ST_MUL_FB;
			end
			ST_MUL_FB: begin
				cmd.mul_fb = 1'b1;
				state_d    = ST_MUL_X;
			end
			ST_MUL_X: begin
				cmd.mul_x = 1'b1;
				state_d   = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				if (sts.idx_zero) begin
					state_d = ST_DONE;
				end else begin
					cmd.idx_dec = 1'b1;
					state_d     = ST_READ;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.frame_end = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register; reset starts with a sweep of the accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	`CFEA_ASSERT_NEXT(a_clear_item_sweeps, clk, arst_n, in_acc && s_tuser, state_q == ST_CLEAR)
	`CFEA_ASSERT_NEXT(a_index_zero_ends_pass, clk, arst_n, state_q == ST_ACC && sts.idx_zero, state_q == ST_DONE)
	`CFEA_ASSERT_PROP(a_result_needs_room, clk, arst_n, cmd.frame_end |-> sts.out_free)

endmodule

`default_nettype wire

// ===== sv/cfea_dp.sv =====
// Datapath of the comb filter energy accumulator: the three stores, the
// shared filter arithmetic, the peak and the result register. Depends on
// cfea_pkg and cfea_ram.
`default_nettype none
`include "comb_filter_energy_accumulator_core_assert.svh"

module cfea_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire cfea_pkg::cmd_t                     cmd,
	output cfea_pkg::sts_t                          sts,
	input  wire logic [cfea_pkg::SAMPLE_BITS-1:0]   sample,
	input  wire logic [cfea_pkg::DELAY_W-1:0]       delay,
	input  wire logic [cfea_pkg::GAIN_W-1:0]        gain,
	input  wire logic                               m_tready,
	output logic                                    m_tvalid,
	output logic [cfea_pkg::PEAK_W-1:0]             peak_level
);

	localparam int BLOCK_SIZE  = cfea_pkg::BLOCK_SIZE;
	localparam int SAMPLE_BITS = cfea_pkg::SAMPLE_BITS;
	localparam int IDX_W       = cfea_pkg::IDX_W;
	localparam int CNT_W       = cfea_pkg::CNT_W;
	localparam int DELAY_W     = cfea_pkg::DELAY_W;
	localparam int GAIN_W      = cfea_pkg::GAIN_W;
	localparam int ACC_W       = cfea_pkg::ACC_W;
	localparam int PEAK_W      = cfea_pkg::PEAK_W;
	localparam int CMP_W       = cfea_pkg::CMP_W;
	localparam int PFB_W       = cfea_pkg::PFB_W;
	localparam int PX_W        = cfea_pkg::PX_W;
	localparam int SUM_W       = cfea_pkg::SUM_W;
	localparam int Q_W         = cfea_pkg::Q_W;

	localparam logic [CMP_W-1:0] BLOCK_CMP = CMP_W'(BLOCK_SIZE);
	localparam logic [CNT_W-1:0] LOAD_FULL = CNT_W'(BLOCK_SIZE);
	localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(BLOCK_SIZE - 1);
	localparam logic [GAIN_W:0]  GAIN_ONE  = (GAIN_W + 1)'(1 << GAIN_W);
	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (GAIN_W - 1));

	// Saturate a shifted filter sum to the sample range.
	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
		input logic signed [Q_W-1:0] q
	);
		logic ovf;
		ovf = !((&q[Q_W-1:SAMPLE_BITS-1]) || !(|q[Q_W-1:SAMPLE_BITS-1]));
		if (!ovf) begin
			sat_sample = q[SAMPLE_BITS-1:0];
		end else if (q[Q_W-1]) begin
			sat_sample = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
		end else begin
			sat_sample = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
		end
	endfunction

	// Saturate an accumulator sum to the signed accumulator range.
	function automatic logic signed [ACC_W-1:0] sat_acc(
		input logic signed [ACC_W:0] a
	);
		if (a[ACC_W] == a[ACC_W-1]) begin
			sat_acc = a[ACC_W-1:0];
		end else if (a[ACC_W]) begin
			sat_acc = {1'b1, {(ACC_W - 1){1'b0}}};
		end else begin
			sat_acc = {1'b0, {(ACC_W - 1){1'b1}}};
		end
	endfunction

	logic [IDX_W-1:0]  clr_q;
	logic [CNT_W-1:0]  load_q;
	logic [IDX_W-1:0]  i_q;
	logic [DELAY_W-1:0] t_q;
	logic [GAIN_W-1:0] alpha_q;
	logic signed [PFB_W-1:0]       prod_fb_q;
	logic signed [PX_W-1:0]        prod_x_q;
	logic signed [SAMPLE_BITS-1:0] filt_q;
	logic [PEAK_W-1:0] peak_q;
	logic              out_valid_q;
	logic [PEAK_W-1:0] out_data_q;

	logic [DELAY_W-1:0] eff_t;
	logic [IDX_W-1:0]   start_idx;
	logic [DELAY_W:0]   twice;
	logic               tap_ok;
	logic               in_low;
	logic [IDX_W-1:0]   tap_addr;
	logic               load_room;

	logic signed [SAMPLE_BITS-1:0] sample_rd;
	logic signed [SAMPLE_BITS-1:0] filt_rd;
	logic signed [ACC_W-1:0]       energy_rd;

	logic signed [SAMPLE_BITS-1:0] fb;
	logic signed [GAIN_W:0]        alpha_s;
	logic [GAIN_W:0]               beta;
	logic signed [GAIN_W+1:0]      beta_s;
	logic signed [PFB_W-1:0]       mul_fb;
	logic signed [PX_W-1:0]        mul_x;
	logic signed [SUM_W-1:0]       sum;
	logic signed [ACC_W:0]         acc_sum;
	logic signed [ACC_W-1:0]       acc_sat;
	logic                          peak_raise;

	logic               energy_we;
	logic [IDX_W-1:0]   energy_waddr;
	logic [ACC_W-1:0]   energy_wdata;

	// Pass bounds: zero delay acts as one, and taps at BLOCK_SIZE-T and above read zero.
	assign eff_t     = (delay == '0) ? DELAY_W'(1) : delay;
	assign start_idx = IDX_W'(BLOCK_CMP - CMP_W'(eff_t) - CMP_W'(1));
	assign twice     = {t_q, 1'b0};
	assign tap_ok    = (CMP_W'(i_q) + CMP_W'(twice)) < BLOCK_CMP;
	assign in_low    = CMP_W'(i_q) < CMP_W'(twice);
	assign tap_addr  = IDX_W'(CMP_W'(i_q) + CMP_W'(t_q));
	assign load_room = (load_q != LOAD_FULL);

	// Status to the controller.
	assign sts.clr_last   = (clr_q == IDX_LAST);
	assign sts.idx_zero   = (i_q == '0);
	assign sts.pass_empty = (CMP_W'(eff_t) >= BLOCK_CMP);
	assign sts.out_free   = !out_valid_q || m_tready;

	// Frame sample store, written while loading and read along the pass.
	cfea_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(BLOCK_SIZE)) u_sample_ram (
		.clk     (clk),
		.wr_en   (cmd.load && load_room),
		.wr_addr (load_q[IDX_W-1:0]),
		.wr_data (sample),
		.rd_addr (i_q),
		.rd_data (sample_rd)
	);

	// Filtered value store; each tap read was written earlier in the same pass.
	cfea_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(BLOCK_SIZE)) u_filt_ram (
		.clk     (clk),
		.wr_en   (cmd.acc),
		.wr_addr (i_q),
		.wr_data (filt_q),
		.rd_addr (tap_addr),
		.rd_data (filt_rd)
	);

	// Energy accumulator store, swept to zero by the clearing pass.
	assign energy_we    = cmd.clr_step || cmd.acc;
	assign energy_waddr = cmd.clr_step ? clr_q : i_q;
	assign energy_wdata = cmd.clr_step ? '0 : acc_sat;

	cfea_ram #(.WIDTH(ACC_W), .DEPTH(BLOCK_SIZE)) u_energy_ram (
		.clk     (clk),
		.wr_en   (energy_we),
		.wr_addr (energy_waddr),
		.wr_data (energy_wdata),
		.rd_addr (i_q),
		.rd_data (energy_rd)
	);

	// Filter arithmetic: one product per step, then the rounded sum.
	assign fb      = tap_ok ? filt_rd : '0;
	assign alpha_s = signed'({1'b0, alpha_q});
	assign beta    = GAIN_ONE - (GAIN_W + 1)'(alpha_q);
	assign beta_s  = signed'({1'b0, beta});
	assign mul_fb  = alpha_s * fb;
	assign mul_x   = beta_s * sample_rd;
	assign sum     = SUM_W'(prod_fb_q) + SUM_W'(prod_x_q) + ROUND_HALF;

	// Accumulation at every index, and peak tracking below twice the delay.
	assign acc_sum    = (ACC_W + 1)'(energy_rd) + (ACC_W + 1)'(filt_q);
	assign acc_sat    = sat_acc(acc_sum);
	assign peak_raise = cmd.acc && in_low && !acc_sat[ACC_W-1]
		&& (acc_sat[PEAK_W-1:0] > peak_q);

	// Arithmetic step registers.
	always_ff @(posedge clk) begin
		if (cmd.pass_start) begin
			t_q     <= eff_t;
			alpha_q <= gain;
		end
		if (cmd.mul_fb) begin
			prod_fb_q <= mul_fb;
		end
		if (cmd.mul_x) begin
			prod_x_q <= mul_x;
		end
		if (cmd.sum) begin
			filt_q <= sat_sample(sum[SUM_W-1:GAIN_W]);
		end
		if (cmd.frame_end) begin
			out_data_q <= peak_q;
		end
	end

	// Counters, peak and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			load_q      <= '0;
			i_q         <= '0;
			peak_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_start) begin
				clr_q <= '0;
			end else if (cmd.clr_step) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (cmd.frame_end) begin
				load_q <= '0;
			end else if (cmd.load && load_room) begin
				load_q <= load_q + CNT_W'(1);
			end
			if (cmd.pass_start) begin
				i_q <= start_idx;
			end else if (cmd.idx_dec) begin
				i_q <= i_q - IDX_W'(1);
			end
			if (cmd.peak_clr) begin
				peak_q <= '0;
			end else if (peak_raise) begin
				peak_q <= acc_sat[PEAK_W-1:0];
			end
			if (cmd.frame_end) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid   = out_valid_q;
	assign peak_level = out_data_q;

	`CFEA_ASSERT_NEXT(a_peak_only_rises, clk, arst_n, !cmd.peak_clr, peak_q >= $past(peak_q))
	`CFEA_ASSERT_PROP(a_load_index_bound, clk, arst_n, load_q <= LOAD_FULL)
	`CFEA_ASSERT_NEXT(a_result_held, clk, arst_n, out_valid_q && !m_tready, out_valid_q)

endmodule

`default_nettype wire

// ===== sv/comb_filter_energy_accumulator_core.sv =====
// Top level of the comb filter energy accumulator: configuration registers on
// the APB-style port, controller and datapath. Depends on cfea_pkg, cfea_ctrl
// and cfea_dp.
//
// A load item (tuser 0) stores its sample at the next frame index. The item
// with tlast set starts a backward comb pass over indices BLOCK_SIZE-T-1 down
// to 0; each index runs through the steps store read, feedback product, sample
// product, rounding and accumulate, and the next index starts only once the
// accumulate step has written its result, because a tap may be the value
// written by the previous index. The peak is then placed in the output
// register once that register is free; a new item is accepted while that
// result still waits to be taken. After reset, and after each clear item
// (tuser 1), the accumulators are swept to zero, and no item is accepted
// during the sweep; configuration writes are taken at any time.
`default_nettype none

module comb_filter_energy_accumulator_core (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [cfea_pkg::S_TDATA_W-1:0]       s_tdata,  // [15:0] sample
	input  wire logic                                 s_tuser,  // [0] mode
	input  wire logic                                 s_tlast,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic [cfea_pkg::M_TDATA_W-1:0]            m_tdata,  // [30:0] peak_level
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [cfea_pkg::APB_ADDR_W-1:0]      paddr,
	input  wire logic [cfea_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [cfea_pkg::APB_DATA_W-1:0]           prdata,
	output logic                                      pready
);

	localparam int DELAY_W    = cfea_pkg::DELAY_W;
	localparam int GAIN_W     = cfea_pkg::GAIN_W;
	localparam int APB_ADDR_W = cfea_pkg::APB_ADDR_W;
	localparam int APB_DATA_W = cfea_pkg::APB_DATA_W;
	localparam int M_TDATA_W  = cfea_pkg::M_TDATA_W;

	logic [DELAY_W-1:0]            delay_q;
	logic [GAIN_W-1:0]             gain_q;
	logic                          cfg_wr;
	logic                          reg_sel;
	cfea_pkg::cmd_t                cmd;
	cfea_pkg::sts_t                sts;
	logic [cfea_pkg::PEAK_W-1:0]   peak_level;

	// Configuration port: always ready, registers at 4-byte spacing.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = paddr[APB_ADDR_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= cfea_pkg::DELAY_RESET;
			gain_q  <= cfea_pkg::GAIN_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				cfea_pkg::REG_DELAY: delay_q <= pwdata[DELAY_W-1:0];
				cfea_pkg::REG_GAIN:  gain_q  <= pwdata[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (reg_sel)
			cfea_pkg::REG_DELAY: prdata = APB_DATA_W'(delay_q);
			cfea_pkg::REG_GAIN:  prdata = APB_DATA_W'(gain_q);
			default:             prdata = '0;
		endcase
	end

	cfea_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cfea_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.sample     (s_tdata[cfea_pkg::SAMPLE_BITS-1:0]),
		.delay      (delay_q),
		.gain       (gain_q),
		.m_tready   (m_tready),
		.m_tvalid   (m_tvalid),
		.peak_level (peak_level)
	);

	// Result item, zero-filled to whole bytes.
	assign m_tdata = M_TDATA_W'(peak_level);

endmodule

`default_nettype wire
